/* sv/snta_pkg.sv */
// Shared types and constants of the seconds/nanos timestamp ALU.
// Depends on nothing; every other file imports it.
package snta_pkg;

    localparam int NUM_STAGES = 5;

    typedef enum logic [2:0] {
        KIND_NORM    = 3'd0,
        KIND_ADD     = 3'd1,
        KIND_SUB     = 3'd2,
        KIND_CMP     = 3'd3,
        KIND_TO_NS   = 3'd4,
        KIND_TO_MS   = 3'd5,
        KIND_FROM_NS = 3'd6,
        KIND_FROM_MS = 3'd7
    } kind_t;

    localparam logic [1:0] ORD_LESS    = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;

    localparam logic [29:0] NS_PER_S   = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS  = 20'd1000000;
    localparam logic [63:0] NS_SEC_MAX = 64'd18446744073;
    localparam logic [63:0] MS_SEC_MAX = 64'd18446744073709551;
    // floor(ns / 1e6) = (ns * MS_RECIP) >> 50 for ns < 2^30
    localparam logic [30:0] MS_RECIP   = 31'd1125899907;
    // floor((c >> 9) / 5^9) = ((c >> 9) * DIV_NS_RECIP) >> 76
    localparam logic [61:0] DIV_NS_RECIP = 62'd38685626227668134;
    // floor((c >> 3) / 125) = ((c >> 3) * DIV_MS_RECIP) >> 68
    localparam logic [61:0] DIV_MS_RECIP = 62'd2361183241434822607;

    typedef logic [NUM_STAGES-1:0] adv_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [63:0] first_seconds;
        logic signed [31:0] first_nanos;
        logic signed [63:0] second_seconds;
        logic signed [31:0] second_nanos;
        logic [63:0]        count_value;
    } req_t;

    typedef struct packed {
        logic [63:0] a_sec;
        logic [29:0] a_ns;
        logic [63:0] b_sec;
        logic [29:0] b_ns;
    } norm_t;

    typedef struct packed {
        logic [63:0] sec;
        logic [29:0] ns;
        logic [1:0]  ordering;
        logic [63:0] count;
        logic        ok;
    } conv_t;

    typedef struct packed {
        logic [63:0] sec;
        logic [29:0] ns;
    } split_t;

endpackage

/* sv/snta_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on snta_pkg.
interface snta_in_if;
    import snta_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [63:0] first_seconds;
    logic signed [31:0] first_nanos;
    logic signed [63:0] second_seconds;
    logic signed [31:0] second_nanos;
    logic [63:0]        count_value;

    modport source (output valid, kind, first_seconds, first_nanos, second_seconds,
                    second_nanos, count_value, input ready);
    modport sink (input valid, kind, first_seconds, first_nanos, second_seconds,
                  second_nanos, count_value, output ready);
endinterface

interface snta_out_if;
    import snta_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_seconds;
    logic [29:0]        result_nanos;
    logic signed [1:0]  ordering;
    logic [63:0]        count_result;
    logic               valid_flag;

    modport source (output valid, result_seconds, result_nanos, ordering, count_result,
                    valid_flag, input ready);
    modport sink (input valid, result_seconds, result_nanos, ordering, count_result,
                  valid_flag, output ready);
endinterface

/* sv/snta_norm.sv */
// Stages 1 to 3: seconds add/subtract, wide nanos, floor split by 1e9, seconds carry.
// Depends on snta_pkg.
module snta_norm (
    input  logic            clk,
    input  snta_pkg::adv_t  adv,
    input  snta_pkg::req_t  req,
    output snta_pkg::norm_t norm
);
    import snta_pkg::*;

    typedef struct packed {
        logic signed [3:0] q;
        logic [29:0]       r;
    } ndiv_t;

    function automatic ndiv_t ndiv(input logic signed [33:0] w);
        ndiv_t             res;
        logic signed [3:0] q;
        logic signed [33:0] lim;
        logic signed [33:0] rem;
        q = -4'sd5;
        for (int k = -4; k <= 4; k++)
        begin
            lim = 34'(longint'(k) * longint'(NS_PER_S));
            if (w >= lim)
            begin
                q = q + 4'sd1;
            end
        end
        rem = w - 34'(longint'(q) * longint'(NS_PER_S));
        res.q = q;
        res.r = rem[29:0];
        return res;
    endfunction

    logic [63:0]        base1_reg, base1_next;
    logic [63:0]        sec2a_reg;
    logic signed [33:0] w1_reg, w1_next;
    logic signed [33:0] w2_reg;
    logic [63:0]        base2_reg;
    logic [63:0]        sec2b_reg;
    ndiv_t              d1_reg, d2_reg;
    norm_t              norm_reg;

    always_comb
    begin
        case (req.kind)
            KIND_ADD:
            begin
                base1_next = req.first_seconds + req.second_seconds;
                w1_next    = 34'(req.first_nanos) + 34'(req.second_nanos);
            end
            KIND_SUB:
            begin
                base1_next = req.first_seconds - req.second_seconds;
                w1_next    = 34'(req.first_nanos) - 34'(req.second_nanos);
            end
            default:
            begin
                base1_next = req.first_seconds;
                w1_next    = 34'(req.first_nanos);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            base1_reg <= base1_next;
            sec2a_reg <= req.second_seconds;
            w1_reg    <= w1_next;
            w2_reg    <= 34'(req.second_nanos);
        end
        if (adv[1])
        begin
            base2_reg <= base1_reg;
            sec2b_reg <= sec2a_reg;
            d1_reg    <= ndiv(w1_reg);
            d2_reg    <= ndiv(w2_reg);
        end
        if (adv[2])
        begin
            norm_reg.a_sec <= base2_reg + {{60{d1_reg.q[3]}}, d1_reg.q};
            norm_reg.a_ns  <= d1_reg.r;
            norm_reg.b_sec <= sec2b_reg + {{60{d2_reg.q[3]}}, d2_reg.q};
            norm_reg.b_ns  <= d2_reg.r;
        end
    end

    assign norm = norm_reg;
endmodule

/* sv/snta_conv.sv */
// Stages 4 and 5: compare and conversion to ns or ms counts.
// Depends on snta_pkg; fed by snta_norm.
module snta_conv (
    input  logic            clk,
    input  snta_pkg::adv_t  adv,
    input  snta_pkg::kind_t kind,
    input  snta_pkg::norm_t norm,
    output snta_pkg::conv_t conv
);
    import snta_pkg::*;

    logic [1:0]  ord_next;
    logic [1:0]  ord4_reg;
    logic        fail_ns4_reg, fail_ms4_reg, is_ms4_reg;
    logic [47:0] ph4_reg;
    logic [46:0] pl4_reg;
    logic [63:0] ms_sec4_reg;
    logic [60:0] ms_prod;
    logic [9:0]  ms_part4_reg;
    logic [63:0] sec4_reg;
    logic [29:0] ns4_reg;
    logic [64:0] ns_sum, ms_sum;
    logic        fail;
    conv_t       conv_reg;

    always_comb
    begin
        if ($signed(norm.a_sec) < $signed(norm.b_sec))
            ord_next = ORD_LESS;
        else if ($signed(norm.a_sec) > $signed(norm.b_sec))
            ord_next = ORD_GREATER;
        else if (norm.a_ns < norm.b_ns)
            ord_next = ORD_LESS;
        else if (norm.a_ns > norm.b_ns)
            ord_next = ORD_GREATER;
        else
            ord_next = ORD_EQUAL;
    end

    assign ms_prod = 61'(norm.a_ns) * 61'(MS_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            ord4_reg     <= ord_next;
            fail_ns4_reg <= norm.a_sec[63] | (norm.a_sec > NS_SEC_MAX);
            fail_ms4_reg <= norm.a_sec[63] | (norm.a_sec > MS_SEC_MAX);
            is_ms4_reg   <= (kind == KIND_TO_MS);
            ph4_reg      <= 48'(norm.a_sec[34:17]) * 48'(NS_PER_S);
            pl4_reg      <= 47'(norm.a_sec[16:0]) * 47'(NS_PER_S);
            ms_sec4_reg  <= (norm.a_sec << 10) - (norm.a_sec << 4) - (norm.a_sec << 3);
            ms_part4_reg <= ms_prod[59:50];
            sec4_reg     <= norm.a_sec;
            ns4_reg      <= norm.a_ns;
        end
    end

    always_comb
    begin
        ns_sum = (65'(ph4_reg) << 17) + 65'(pl4_reg) + 65'(ns4_reg);
        ms_sum = 65'(ms_sec4_reg) + 65'(ms_part4_reg);
        fail   = is_ms4_reg ? (fail_ms4_reg | ms_sum[64]) : (fail_ns4_reg | ns_sum[64]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            conv_reg.sec      <= sec4_reg;
            conv_reg.ns       <= ns4_reg;
            conv_reg.ordering <= ord4_reg;
            conv_reg.ok       <= !fail;
            conv_reg.count    <= fail ? 64'd0 : (is_ms4_reg ? ms_sum[63:0] : ns_sum[63:0]);
        end
    end

    assign conv = conv_reg;
endmodule

/* sv/snta_count.sv */
// Stages 1 to 5: split a ns or ms count into seconds and nanos by reciprocal
// multiplication in partial products. Depends on snta_pkg.
module snta_count (
    input  logic             clk,
    input  snta_pkg::adv_t   adv,
    input  snta_pkg::kind_t  kind,
    input  logic [63:0]      count_value,
    output snta_pkg::split_t split
);
    import snta_pkg::*;

    logic         is_ns_next;
    logic [60:0]  cs;
    logic [61:0]  recip;
    logic [60:0]  pp_hh_reg, pp_hl_reg;
    logic [61:0]  pp_lh_reg, pp_ll_reg;
    logic [63:0]  c1_reg, c2_reg, c3_reg;
    logic         is_ns1_reg, is_ns2_reg, is_ns3_reg, is_ns4_reg;
    logic [123:0] full;
    logic [63:0]  q2_reg, q3_reg, q4_reg;
    logic [47:0]  qh3_reg;
    logic [46:0]  ql3_reg;
    logic [63:0]  qm3_reg;
    logic [63:0]  qd, rem;
    logic [29:0]  r4_reg;
    split_t       split_reg;

    always_comb
    begin
        is_ns_next = (kind == KIND_FROM_NS);
        cs    = is_ns_next ? 61'(count_value >> 9) : count_value[63:3];
        recip = is_ns_next ? DIV_NS_RECIP : DIV_MS_RECIP;
    end

    assign full = (124'(pp_hh_reg) << 62) + (124'(pp_hl_reg) << 31)
                + (124'(pp_lh_reg) << 31) + 124'(pp_ll_reg);

    always_comb
    begin
        qd  = is_ns3_reg ? ((64'(qh3_reg) << 17) + 64'(ql3_reg)) : qm3_reg;
        rem = c3_reg - qd;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pp_hh_reg  <= 61'(cs[60:31]) * 61'(recip[61:31]);
            pp_hl_reg  <= 61'(cs[60:31]) * 61'(recip[30:0]);
            pp_lh_reg  <= 62'(cs[30:0]) * 62'(recip[61:31]);
            pp_ll_reg  <= 62'(cs[30:0]) * 62'(recip[30:0]);
            c1_reg     <= count_value;
            is_ns1_reg <= is_ns_next;
        end
        if (adv[1])
        begin
            q2_reg     <= is_ns1_reg ? 64'(full[123:76]) : 64'(full[123:68]);
            c2_reg     <= c1_reg;
            is_ns2_reg <= is_ns1_reg;
        end
        if (adv[2])
        begin
            qh3_reg    <= 48'(q2_reg[34:17]) * 48'(NS_PER_S);
            ql3_reg    <= 47'(q2_reg[16:0]) * 47'(NS_PER_S);
            qm3_reg    <= (q2_reg << 10) - (q2_reg << 4) - (q2_reg << 3);
            q3_reg     <= q2_reg;
            c3_reg     <= c2_reg;
            is_ns3_reg <= is_ns2_reg;
        end
        if (adv[3])
        begin
            r4_reg     <= rem[29:0];
            q4_reg     <= q3_reg;
            is_ns4_reg <= is_ns3_reg;
        end
        if (adv[4])
        begin
            split_reg.sec <= q4_reg;
            split_reg.ns  <= is_ns4_reg ? r4_reg : 30'(r4_reg[9:0] * NS_PER_MS);
        end
    end

    assign split = split_reg;
endmodule

/* sv/seconds_nanos_time_alu_top.sv */
// Top level of the seconds/nanos timestamp ALU: stage control and result select.
// Depends on snta_pkg, snta_if, snta_norm, snta_conv and snta_count.
//
// Takes one request word per clock while req.ready is high, and returns one
// response word per request, in order, from the last of the five register
// stages: seconds/nanos sums, the floor split of nanos by 1e9, the seconds carry,
// the conversion partial products, and the final count sums that land in the
// output register. Each stage holds its word only while the next is full and
// stalled, so bubbles close up and a stalled response does not block requests
// until all five stages are occupied.
module seconds_nanos_time_alu_top (
    input logic     clk,
    input logic     rst_n,
    snta_in_if.sink   req,
    snta_out_if.source rsp
);
    import snta_pkg::*;

    adv_t   adv;
    logic [NUM_STAGES-1:0] valid_reg;
    kind_t  kind_reg [NUM_STAGES];
    req_t   req_word;
    norm_t  norm;
    conv_t  conv;
    split_t split;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rsp.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign req.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= req.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            kind_reg[0] <= kind_t'(req.kind);
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                kind_reg[k] <= kind_reg[k-1];
            end
        end
    end

    always_comb
    begin
        req_word.kind           = kind_t'(req.kind);
        req_word.first_seconds  = req.first_seconds;
        req_word.first_nanos    = req.first_nanos;
        req_word.second_seconds = req.second_seconds;
        req_word.second_nanos   = req.second_nanos;
        req_word.count_value    = req.count_value;
    end

    snta_norm u_norm (
        .clk  (clk),
        .adv  (adv),
        .req  (req_word),
        .norm (norm)
    );

    snta_conv u_conv (
        .clk  (clk),
        .adv  (adv),
        .kind (kind_reg[2]),
        .norm (norm),
        .conv (conv)
    );

    snta_count u_count (
        .clk         (clk),
        .adv         (adv),
        .kind        (req_word.kind),
        .count_value (req.count_value),
        .split       (split)
    );

    assign rsp.valid = valid_reg[NUM_STAGES-1];

    always_comb
    begin
        rsp.result_seconds = '0;
        rsp.result_nanos   = '0;
        rsp.ordering       = ORD_EQUAL;
        rsp.count_result   = '0;
        rsp.valid_flag     = 1'b1;
        case (kind_reg[NUM_STAGES-1])
            KIND_NORM, KIND_ADD, KIND_SUB:
            begin
                rsp.result_seconds = conv.sec;
                rsp.result_nanos   = conv.ns;
            end
            KIND_CMP:
            begin
                rsp.ordering = conv.ordering;
            end
            KIND_TO_NS, KIND_TO_MS:
            begin
                rsp.count_result = conv.count;
                rsp.valid_flag   = conv.ok;
            end
            KIND_FROM_NS, KIND_FROM_MS:
            begin
                rsp.result_seconds = split.sec;
                rsp.result_nanos   = split.ns;
            end
            default:
            begin
                rsp.valid_flag = 1'b1;
            end
        endcase
    end

    a_nanos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.result_nanos < NS_PER_S)
        else $error("result nanos out of range");

    a_ordering_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.ordering != 2'b10)
        else $error("bad ordering code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.valid_flag |-> rsp.count_result == 64'd0)
        else $error("failed conversion with nonzero count");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !rsp.ready |-> !req.ready)
        else $error("request taken while pipeline full and stalled");

endmodule
